[sv/trp_pkg.sv]
// shared types and constants for the transaction record stream parser
`timescale 1ns / 1ps
`default_nettype none

package trp_pkg;

  // parse phases
  localparam logic [3:0] PhVersion   = 4'd0;
  localparam logic [3:0] PhIncount   = 4'd1;
  localparam logic [3:0] PhIdLen     = 4'd2;
  localparam logic [3:0] PhIdBytes   = 4'd3;
  localparam logic [3:0] PhOutidx    = 4'd4;
  localparam logic [3:0] PhSigLen    = 4'd5;
  localparam logic [3:0] PhSigBytes  = 4'd6;
  localparam logic [3:0] PhKeyLen    = 4'd7;
  localparam logic [3:0] PhKeyBytes  = 4'd8;
  localparam logic [3:0] PhOutcount  = 4'd9;
  localparam logic [3:0] PhValue     = 4'd10;
  localparam logic [3:0] PhHashLen   = 4'd11;
  localparam logic [3:0] PhHashBytes = 4'd12;
  localparam logic [3:0] PhLocktime  = 4'd13;
  localparam logic [3:0] PhDone      = 4'd14;

  // field kinds
  localparam logic [3:0] KindVersion  = 4'd0;
  localparam logic [3:0] KindIncount  = 4'd1;
  localparam logic [3:0] KindIdByte   = 4'd2;
  localparam logic [3:0] KindOutidx   = 4'd3;
  localparam logic [3:0] KindSigByte  = 4'd4;
  localparam logic [3:0] KindKeyByte  = 4'd5;
  localparam logic [3:0] KindOutcount = 4'd6;
  localparam logic [3:0] KindValue    = 4'd7;
  localparam logic [3:0] KindHashByte = 4'd8;
  localparam logic [3:0] KindLocktime = 4'd9;
  localparam logic [3:0] KindNone     = 4'd10;

  // final status codes
  localparam logic [1:0] StatBusy     = 2'd0;
  localparam logic [1:0] StatOk       = 2'd1;
  localparam logic [1:0] StatTrunc    = 2'd2;
  localparam logic [1:0] StatTrailing = 2'd3;

  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  byte_cnt;
    logic [63:0] shift;
    logic [31:0] var_left;
    logic [31:0] entries_left;
    logic [31:0] entry_cnt;
    logic        trailing;
  } state_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [7:0]  payload_byte;
    logic [63:0] number_value;
    logic        number_valid;
    logic [31:0] entry_index;
    logic [1:0]  status;
  } result_t;

  localparam state_t StateReset = '{
    phase:        PhVersion,
    byte_cnt:     3'd0,
    shift:        64'd0,
    var_left:     32'd0,
    entries_left: 32'd0,
    entry_cnt:    32'd0,
    trailing:     1'b0
  };

endpackage

`default_nettype wire

[sv/trp_step.sv]
// next-state and result logic for one record byte
`timescale 1ns / 1ps
`default_nettype none

module trp_step (
  input  trp_pkg::state_t  cur_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_i,
  output trp_pkg::state_t  nxt_o,
  output trp_pkg::result_t res_o
);

  trp_pkg::state_t  nxt;
  trp_pkg::result_t res;
  logic [63:0] merged;
  logic [31:0] v32;
  logic [2:0]  last_byte;
  logic        fin_in;
  logic        fin_out;
  logic [31:0] left_dec;

  always_comb begin
    nxt     = cur_i;
    fin_in  = 1'b0;
    fin_out = 1'b0;
    merged  = cur_i.shift | ({56'd0, data_byte_i} << {cur_i.byte_cnt, 3'b000});
    v32     = merged[31:0];
    last_byte = (cur_i.phase == trp_pkg::PhValue) ? 3'd7 : 3'd3;
    left_dec  = cur_i.var_left - 32'd1;

    res.field_kind   = trp_pkg::KindNone;
    res.payload_byte = 8'd0;
    res.number_value = 64'd0;
    res.number_valid = 1'b0;
    res.entry_index  = 32'd0;
    res.status       = trp_pkg::StatBusy;

    if (cur_i.phase inside {[trp_pkg::PhIdLen : trp_pkg::PhKeyBytes],
                            [trp_pkg::PhValue : trp_pkg::PhHashBytes]}) begin
      res.entry_index = cur_i.entry_cnt;
    end

    if (cur_i.phase inside {trp_pkg::PhIdBytes, trp_pkg::PhSigBytes,
                            trp_pkg::PhKeyBytes, trp_pkg::PhHashBytes}) begin
      case (cur_i.phase)
        trp_pkg::PhIdBytes:  res.field_kind = trp_pkg::KindIdByte;
        trp_pkg::PhSigBytes: res.field_kind = trp_pkg::KindSigByte;
        trp_pkg::PhKeyBytes: res.field_kind = trp_pkg::KindKeyByte;
        default:             res.field_kind = trp_pkg::KindHashByte;
      endcase
      res.payload_byte = data_byte_i;
      nxt.var_left     = left_dec;
      if (left_dec == 32'd0) begin
        case (cur_i.phase)
          trp_pkg::PhIdBytes:  nxt.phase = trp_pkg::PhOutidx;
          trp_pkg::PhSigBytes: nxt.phase = trp_pkg::PhKeyLen;
          trp_pkg::PhKeyBytes: fin_in = 1'b1;
          default:             fin_out = 1'b1;
        endcase
      end
    end else if (cur_i.phase >= trp_pkg::PhDone) begin
      nxt.trailing = 1'b1;
      nxt.phase    = trp_pkg::PhDone;
    end else if (cur_i.byte_cnt != last_byte) begin
      nxt.byte_cnt = cur_i.byte_cnt + 3'd1;
      nxt.shift    = merged;
    end else begin
      nxt.byte_cnt = 3'd0;
      nxt.shift    = 64'd0;
      case (cur_i.phase)
        trp_pkg::PhVersion: begin
          res.field_kind = trp_pkg::KindVersion;
          res.number_valid = 1'b1;
          nxt.phase = trp_pkg::PhIncount;
        end
        trp_pkg::PhIncount: begin
          res.field_kind = trp_pkg::KindIncount;
          res.number_valid = 1'b1;
          nxt.entries_left = v32;
          nxt.entry_cnt    = 32'd0;
          nxt.phase = (v32 == 32'd0) ? trp_pkg::PhOutcount : trp_pkg::PhIdLen;
        end
        trp_pkg::PhIdLen: begin
          nxt.var_left = v32;
          nxt.phase = (v32 == 32'd0) ? trp_pkg::PhOutidx : trp_pkg::PhIdBytes;
        end
        trp_pkg::PhOutidx: begin
          res.field_kind = trp_pkg::KindOutidx;
          res.number_valid = 1'b1;
          nxt.phase = trp_pkg::PhSigLen;
        end
        trp_pkg::PhSigLen: begin
          nxt.var_left = v32;
          nxt.phase = (v32 == 32'd0) ? trp_pkg::PhKeyLen : trp_pkg::PhSigBytes;
        end
        trp_pkg::PhKeyLen: begin
          nxt.var_left = v32;
          if (v32 == 32'd0) begin
            fin_in = 1'b1;
          end else begin
            nxt.phase = trp_pkg::PhKeyBytes;
          end
        end
        trp_pkg::PhOutcount: begin
          res.field_kind = trp_pkg::KindOutcount;
          res.number_valid = 1'b1;
          nxt.entries_left = v32;
          nxt.entry_cnt    = 32'd0;
          nxt.phase = (v32 == 32'd0) ? trp_pkg::PhLocktime : trp_pkg::PhValue;
        end
        trp_pkg::PhValue: begin
          res.field_kind = trp_pkg::KindValue;
          res.number_valid = 1'b1;
          nxt.phase = trp_pkg::PhHashLen;
        end
        trp_pkg::PhHashLen: begin
          nxt.var_left = v32;
          if (v32 == 32'd0) begin
            fin_out = 1'b1;
          end else begin
            nxt.phase = trp_pkg::PhHashBytes;
          end
        end
        default: begin
          res.field_kind = trp_pkg::KindLocktime;
          res.number_valid = 1'b1;
          nxt.phase = trp_pkg::PhDone;
        end
      endcase
      if (res.number_valid) begin
        res.number_value = merged;
      end
    end

    // end of an input or output entry
    if (fin_in || fin_out) begin
      nxt.entries_left = cur_i.entries_left - 32'd1;
      if (nxt.entries_left == 32'd0) begin
        nxt.entry_cnt = 32'd0;
        nxt.phase = fin_in ? trp_pkg::PhOutcount : trp_pkg::PhLocktime;
      end else begin
        nxt.entry_cnt = cur_i.entry_cnt + 32'd1;
        nxt.phase = fin_in ? trp_pkg::PhIdLen : trp_pkg::PhValue;
      end
    end

    if (last_i) begin
      if (nxt.trailing) begin
        res.status = trp_pkg::StatTrailing;
      end else if (nxt.phase == trp_pkg::PhDone) begin
        res.status = trp_pkg::StatOk;
      end else begin
        res.status = trp_pkg::StatTrunc;
      end
      nxt = trp_pkg::StateReset;
    end

    nxt_o = nxt;
    res_o = res;
  end

endmodule

`default_nettype wire

[sv/tx_record_stream_parser.sv]
// top level of the transaction record stream parser
`timescale 1ns / 1ps
`default_nettype none

// byte-serial parser for one transaction record (version, inputs with id,
// output index, signature and key, outputs with value and key hash, lock
// time; all numbers little-endian). every accepted byte gives exactly one
// result item in the next cycle: numeric fields are reported on the byte that
// completes them, payload bytes come tagged with their kind, and the byte
// marked last carries the final status, after which the parser is back at
// the start of a record. throughput is one byte per clock unless the
// consumer stalls; a single result register sits behind the parse logic. the
// input side stays ready while the result register is empty or being taken
// in the same cycle, so a stalled consumer holds at most one result.

module tx_record_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  field_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [63:0] number_value_o,
  output logic        number_valid_o,
  output logic [31:0] entry_index_o,
  output logic [1:0]  status_o
);

  // parse state and the result register
  trp_pkg::state_t  state_q;
  trp_pkg::state_t  state_d;
  trp_pkg::result_t res_q;
  trp_pkg::result_t res_d;
  logic             out_valid_q;
  logic             in_fire;

  // one item in flight at most in the result register
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  trp_step u_step (
    .cur_i       (state_q),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  // state advances only on an accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trp_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign field_kind_o   = res_q.field_kind;
  assign payload_byte_o = res_q.payload_byte;
  assign number_value_o = res_q.number_value;
  assign number_valid_o = res_q.number_valid;
  assign entry_index_o  = res_q.entry_index;
  assign status_o       = res_q.status;

`ifndef SYNTHESIS
  // the byte marked last always returns the parser to the record start
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_i |=> state_q.phase == trp_pkg::PhVersion && !state_q.trailing)
    else $error("parser not cleared after last byte");

  // a reported number always carries a numeric field kind
  a_num_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && number_valid_o |->
      field_kind_o != trp_pkg::KindNone && field_kind_o != trp_pkg::KindIdByte &&
      field_kind_o != trp_pkg::KindSigByte && field_kind_o != trp_pkg::KindKeyByte &&
      field_kind_o != trp_pkg::KindHashByte)
    else $error("number reported with wrong kind");

  // a result taken without a new byte leaves the register empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !in_valid_i |=> !out_valid_o)
    else $error("result register did not drain");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench for the transaction record stream parser
`timescale 1ns / 1ps

// drives whole transaction records into the parser one byte per item and
// checks every result item against a byte-level parse model kept here.
// records are mostly well formed with random content, so that entries,
// payload runs and the lock time are all reached. the rest are truncated,
// have trailing bytes, carry huge counts or lengths, or are plain noise.
// both handshakes idle in random bursts. once, the consumer holds off for
// a long stretch so that the result register fills and the input stalls.

module tb_top;

  localparam int ItemTarget    = 730;  // directed bytes plus the random ones
  localparam int WatchdogLimit = 2000; // cycles with no handshake at all
  localparam int SettleCycles  = 8;    // margin behind the result register
  localparam int CalmTail      = 60;   // no idling for the last items
  localparam int HoldCycles    = 80;   // long consumer stall
  localparam int HoldAfter     = 200;  // results taken before that stall

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rec_byte_t;

  logic clk;
  logic rst_n = 1'b0;

  // parser inputs, all known from time zero
  logic       in_valid  = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic       last_flag = 1'b0;
  logic       out_ready = 1'b1;

  // parser outputs
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  field_kind;
  logic [7:0]  payload_byte;
  logic [63:0] number_value;
  logic        number_valid;
  logic [31:0] entry_index;
  logic [1:0]  status;

  rec_byte_t          pending_bytes[$];  // stimulus not yet offered
  trp_pkg::result_t   awaited_fields[$]; // predicted results, oldest first
  logic [7:0]         rec_buf[$];        // record under construction
  int                 error_count = 0;
  int                 total_items = 0;

  // parse model state
  logic [3:0]  rp_phase;
  logic [2:0]  rp_nbyte;
  logic [63:0] rp_shift;
  logic [31:0] rp_var_left;
  logic [31:0] rp_entries_left;
  logic [31:0] rp_entry_cnt;
  logic        rp_trailing;

  tx_record_stream_parser i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .last_i         (last_flag),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .field_kind_o   (field_kind),
    .payload_byte_o (payload_byte),
    .number_value_o (number_value),
    .number_valid_o (number_valid),
    .entry_index_o  (entry_index),
    .status_o       (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  //--------------------------------------------------------------------------
  // byte-level parse model
  //--------------------------------------------------------------------------

  function automatic void clear_parse();
    rp_phase        = trp_pkg::PhVersion;
    rp_nbyte        = '0;
    rp_shift        = '0;
    rp_var_left     = '0;
    rp_entries_left = '0;
    rp_entry_cnt    = '0;
    rp_trailing     = 1'b0;
  endfunction

  // one entry of a list is done: go to the next one or past the list
  function automatic void close_entry(input logic [3:0] after_list,
                                      input logic [3:0] next_entry);
    rp_entries_left = rp_entries_left - 32'd1;
    if (rp_entries_left == 32'd0) begin
      rp_entry_cnt = '0;
      rp_phase     = after_list;
    end else begin
      rp_entry_cnt = rp_entry_cnt + 32'd1;
      rp_phase     = next_entry;
    end
  endfunction

  function automatic trp_pkg::result_t parse_byte(input logic [7:0] b, input logic lst);
    trp_pkg::result_t r;
    logic [3:0]  ph;
    int          width;
    logic [63:0] v;
    r            = '0;
    r.field_kind = trp_pkg::KindNone;
    r.status     = trp_pkg::StatBusy;
    ph           = rp_phase;

    // entry index only while inside an input or an output entry
    if ((ph >= trp_pkg::PhIdLen && ph <= trp_pkg::PhKeyBytes) ||
        (ph >= trp_pkg::PhValue && ph <= trp_pkg::PhHashBytes))
      r.entry_index = rp_entry_cnt;

    if (ph == trp_pkg::PhIdBytes || ph == trp_pkg::PhSigBytes ||
        ph == trp_pkg::PhKeyBytes || ph == trp_pkg::PhHashBytes) begin
      case (ph)
        trp_pkg::PhIdBytes:  r.field_kind = trp_pkg::KindIdByte;
        trp_pkg::PhSigBytes: r.field_kind = trp_pkg::KindSigByte;
        trp_pkg::PhKeyBytes: r.field_kind = trp_pkg::KindKeyByte;
        default:             r.field_kind = trp_pkg::KindHashByte;
      endcase
      r.payload_byte = b;
      rp_var_left    = rp_var_left - 32'd1;
      if (rp_var_left == 32'd0) begin
        case (ph)
          trp_pkg::PhIdBytes:  rp_phase = trp_pkg::PhOutidx;
          trp_pkg::PhSigBytes: rp_phase = trp_pkg::PhKeyLen;
          trp_pkg::PhKeyBytes: close_entry(trp_pkg::PhOutcount, trp_pkg::PhIdLen);
          default:             close_entry(trp_pkg::PhLocktime, trp_pkg::PhValue);
        endcase
      end
    end else if (ph >= trp_pkg::PhDone) begin
      // anything after the lock time is trailing garbage
      rp_trailing = 1'b1;
      rp_phase    = trp_pkg::PhDone;
    end else begin
      width    = (ph == trp_pkg::PhValue) ? 8 : 4;
      rp_shift = rp_shift | ({56'd0, b} << (rp_nbyte * 8));
      if (rp_nbyte + 1 < width) begin
        rp_nbyte = rp_nbyte + 3'd1;
      end else begin
        v        = rp_shift;
        rp_nbyte = '0;
        rp_shift = '0;
        case (ph)
          trp_pkg::PhVersion: begin
            r.field_kind = trp_pkg::KindVersion;
            r.number_value = v; r.number_valid = 1'b1;
            rp_phase = trp_pkg::PhIncount;
          end
          trp_pkg::PhIncount: begin
            r.field_kind = trp_pkg::KindIncount;
            r.number_value = v; r.number_valid = 1'b1;
            rp_entries_left = v[31:0];
            rp_entry_cnt    = '0;
            rp_phase = (v[31:0] == 32'd0) ? trp_pkg::PhOutcount : trp_pkg::PhIdLen;
          end
          trp_pkg::PhIdLen: begin
            rp_var_left = v[31:0];
            rp_phase = (v[31:0] == 32'd0) ? trp_pkg::PhOutidx : trp_pkg::PhIdBytes;
          end
          trp_pkg::PhOutidx: begin
            r.field_kind = trp_pkg::KindOutidx;
            r.number_value = v; r.number_valid = 1'b1;
            rp_phase = trp_pkg::PhSigLen;
          end
          trp_pkg::PhSigLen: begin
            rp_var_left = v[31:0];
            rp_phase = (v[31:0] == 32'd0) ? trp_pkg::PhKeyLen : trp_pkg::PhSigBytes;
          end
          trp_pkg::PhKeyLen: begin
            rp_var_left = v[31:0];
            if (v[31:0] == 32'd0) close_entry(trp_pkg::PhOutcount, trp_pkg::PhIdLen);
            else rp_phase = trp_pkg::PhKeyBytes;
          end
          trp_pkg::PhOutcount: begin
            r.field_kind = trp_pkg::KindOutcount;
            r.number_value = v; r.number_valid = 1'b1;
            rp_entries_left = v[31:0];
            rp_entry_cnt    = '0;
            rp_phase = (v[31:0] == 32'd0) ? trp_pkg::PhLocktime : trp_pkg::PhValue;
          end
          trp_pkg::PhValue: begin
            r.field_kind = trp_pkg::KindValue;
            r.number_value = v; r.number_valid = 1'b1;
            rp_phase = trp_pkg::PhHashLen;
          end
          trp_pkg::PhHashLen: begin
            rp_var_left = v[31:0];
            if (v[31:0] == 32'd0) close_entry(trp_pkg::PhLocktime, trp_pkg::PhValue);
            else rp_phase = trp_pkg::PhHashBytes;
          end
          default: begin
            r.field_kind = trp_pkg::KindLocktime;
            r.number_value = v; r.number_valid = 1'b1;
            rp_phase = trp_pkg::PhDone;
          end
        endcase
      end
    end

    // final status on the byte marked last, then back to the record start
    if (lst) begin
      if (rp_trailing) r.status = trp_pkg::StatTrailing;
      else if (rp_phase == trp_pkg::PhDone) r.status = trp_pkg::StatOk;
      else r.status = trp_pkg::StatTrunc;
      clear_parse();
    end
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // record builders
  //--------------------------------------------------------------------------

  task automatic put_number(input logic [63:0] v, input int nbytes);
    for (int k = 0; k < nbytes; k++) rec_buf = {rec_buf, v[8*k +: 8]};
  endtask

  task automatic put_random_bytes(input int n);
    for (int k = 0; k < n; k++) rec_buf = {rec_buf, 8'($urandom)};
  endtask

  // length prefix followed by that many random bytes
  task automatic put_blob(input int len);
    put_number(64'(len), 4);
    put_random_bytes(len);
  endtask

  function automatic int pick_len();
    return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 5));
  endfunction

  task automatic build_record();
    int n_in;
    int n_out;
    n_in  = $urandom_range(0, 3);
    n_out = $urandom_range(0, 3);
    put_number(64'($urandom), 4);
    put_number(64'(n_in), 4);
    for (int e = 0; e < n_in; e++) begin
      put_blob(pick_len());
      put_number(64'($urandom), 4);
      put_blob(pick_len());
      put_blob(pick_len());
    end
    put_number(64'(n_out), 4);
    for (int e = 0; e < n_out; e++) begin
      put_number({32'($urandom), 32'($urandom)}, 8);
      put_blob(pick_len());
    end
    put_number(64'($urandom), 4);
  endtask

  // moves the record into the stimulus queue, last flag on its final byte
  task automatic flush_record();
    rec_byte_t it;
    while (rec_buf.size() > 0) begin
      it.data = rec_buf.pop_front();
      it.last = (rec_buf.size() == 0);
      pending_bytes = {pending_bytes, it};
    end
  endtask

  task automatic build_stimulus();
    int pick;
    int cut;
    // directed: a lone byte marked last, so truncated inside the version
    rec_buf = {rec_buf, 8'hff};
    flush_record();
    // directed: smallest complete record, lock time ends on the last byte
    put_number(64'hffff_ffff, 4);
    put_number(64'd0, 4);
    put_number(64'd0, 4);
    put_number(64'd0, 4);
    flush_record();
    // directed: huge input count, then the bytes run out in a length prefix
    put_number(64'd0, 4);
    put_number(64'hffff_ffff, 4);
    rec_buf = {rec_buf, 8'h00};
    flush_record();

    while (pending_bytes.size() < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        build_record();
      end else if (pick < 80) begin
        build_record();
        put_random_bytes($urandom_range(1, 4));
      end else if (pick < 92) begin
        build_record();
        cut = $urandom_range(1, rec_buf.size() - 1);
        while (rec_buf.size() > cut) void'(rec_buf.pop_back());
      end else if (pick < 96) begin
        // huge count or length: the record can only end truncated
        put_number(64'($urandom), 4);
        case ($urandom_range(0, 2))
          0: put_number(64'($urandom | 32'h8000_0000), 4);
          1: begin
            put_number(64'd1, 4);
            put_number(64'($urandom | 32'h8000_0000), 4);
          end
          default: begin
            put_number(64'd0, 4);
            put_number(64'hffff_ffff, 4);
          end
        endcase
        put_random_bytes($urandom_range(1, 24));
      end else begin
        put_random_bytes($urandom_range(1, 20));
      end
      flush_record();
    end
    total_items = pending_bytes.size();
  endtask

  //--------------------------------------------------------------------------
  // checking
  //--------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  //--------------------------------------------------------------------------
  // driver: offers queued bytes, predicts on acceptance
  //--------------------------------------------------------------------------

  int send_gap  = 0;
  int sent_cnt  = 0;

  always @(posedge clk) begin : drive_p
    rec_byte_t        it;
    int               gap_odds;
    trp_pkg::result_t pred;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pred = parse_byte(data_byte, last_flag);
        awaited_fields = {awaited_fields, pred};
      end

      // a new byte may go out when nothing is offered or the offer was taken
      if (!in_valid || in_ready) begin
        // idling density changes every 64 bytes, none in the tail
        case ((sent_cnt / 64) % 3)
          0:       gap_odds = 0;
          1:       gap_odds = 8;
          default: gap_odds = 3;
        endcase
        if (pending_bytes.size() < CalmTail) gap_odds = 0;

        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          send_gap = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else begin
          it = pending_bytes.pop_front();
          data_byte <= it.data;
          last_flag <= it.last;
          in_valid  <= 1'b1;
          sent_cnt++;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // monitor: checks taken results, throttles the consumer side
  //--------------------------------------------------------------------------

  int  stall_left   = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  int  results_seen = 0;

  always @(posedge clk) begin : monitor_p
    trp_pkg::result_t want;
    logic             ready_next;
    int               stall_odds;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_fields.size() == 0) begin
          report_error($sformatf("unexpected result, kind %0d status %0d",
                                 field_kind, status));
        end else begin
          want = awaited_fields.pop_front();
          if (field_kind !== want.field_kind)
            report_error($sformatf("field_kind %0d, want %0d", field_kind, want.field_kind));
          if (payload_byte !== want.payload_byte)
            report_error($sformatf("payload_byte %0h, want %0h",
                                   payload_byte, want.payload_byte));
          if (number_value !== want.number_value)
            report_error($sformatf("number_value %0h, want %0h",
                                   number_value, want.number_value));
          if (number_valid !== want.number_valid)
            report_error($sformatf("number_valid %0b, want %0b",
                                   number_valid, want.number_valid));
          if (entry_index !== want.entry_index)
            report_error($sformatf("entry_index %0d, want %0d",
                                   entry_index, want.entry_index));
          if (status !== want.status)
            report_error($sformatf("status %0d, want %0d", status, want.status));
        end
      end

      case ((results_seen / 48) % 3)
        0:       stall_odds = 4;
        1:       stall_odds = 0;
        default: stall_odds = 10;
      endcase
      if (results_seen >= total_items - CalmTail) stall_odds = 0;

      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        // long back-pressure: the sender keeps offering and gets stalled
        hold_done  = 1'b1;
        hold_left  = HoldCycles - 1;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        stall_left = $urandom_range(0, 10);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  //--------------------------------------------------------------------------
  // watchdog: too long without any handshake means the parser hung
  //--------------------------------------------------------------------------

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  //--------------------------------------------------------------------------
  // sequence: build stimulus, reset, wait for drain, verdict
  //--------------------------------------------------------------------------

  initial begin
    clear_parse();
    build_stimulus();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    while (awaited_fields.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (awaited_fields.size() > 0)
      report_error($sformatf("%0d results never arrived", awaited_fields.size()));

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
